// ===== design/qfr_pkg.sv =====
// ============================================================================
// qfr_pkg: shared types and constants for quaternion frame rotation
// Widths of the fixed-point datapath, the divide-by-10^8 constants and the
// per-row state that travels through the pipelined long division.
// ============================================================================
package qfr_pkg;

    // Field widths
    localparam int IN_W     = 16;
    localparam int EARTH_W  = 20;

    // Datapath widths
    localparam int PROD_W   = 32;               // 16x16 quaternion products
    localparam int MAT_W    = 34;               // matrix entries, scale 10^8
    localparam int TERM_W   = MAT_W + IN_W;     // entry * accel
    localparam int SUM_W    = TERM_W + 2;       // three-term row sum

    // 10^8 = 2^8 * 390625: drop 8 bits, then divide by the odd part
    localparam int SHIFT_W  = 8;
    localparam int U_W      = SUM_W - SHIFT_W;
    localparam int Q_W      = 20;               // quotient magnitude bits
    localparam int R_W      = 19;               // remainder bits, DIV_ODD < 2^R_W

    // Long division: DIV_STAGES register stages, DIV_STEPS bits each
    localparam int DIV_STAGES = 4;
    localparam int DIV_STEPS  = Q_W / DIV_STAGES;

    // Register stages ahead of the output register
    localparam int PIPE_DEPTH = 5 + DIV_STAGES;

    localparam logic signed [MAT_W-1:0] QSCALE_SQ = 34'sd100000000;
    localparam logic [R_W-1:0]          DIV_ODD   = 19'd390625;
    // 2^Q_W * DIV_ODD: at or above this the quotient does not fit in Q_W bits
    localparam logic [U_W-1:0]          OVER_LIM  = 44'd409600000000;

    // Output range
    localparam logic signed [EARTH_W-1:0] EARTH_MAX = 20'sh7FFFF;
    localparam logic signed [EARTH_W-1:0] EARTH_MIN = 20'sh80000;
    localparam logic [Q_W-1:0]            POS_LIMIT = 20'd524287;
    localparam logic [Q_W-1:0]            NEG_LIMIT = 20'd524288;

    typedef logic signed [EARTH_W-1:0] earth_t;

    // One output row inside the divider
    typedef struct packed {
        logic [R_W-1:0] rem;    // partial remainder, below DIV_ODD unless over is set
        logic [Q_W-1:0] quo;    // quotient bits produced so far
        logic [Q_W-1:0] low;    // dividend bits not yet consumed, MSB first
        logic           neg;    // row sum was negative
        logic           over;   // magnitude far beyond the output range
    } div_t;

endpackage

// ===== design/quaternion_frame_rotation_top.sv =====
// ============================================================================
// quaternion_frame_rotation_top: sensor-frame to earth-frame acceleration
// Builds the rotation matrix of a quaternion scaled by 10000, applies it to a
// raw accelerometer vector, divides by 10^8 toward zero and clips to 20 bits.
// ============================================================================
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+----------------------------------
//  in      | to block  | in_valid/in_stall  | accel_x/y/z, quat_w/x/y/z
//  out     | from block| out_valid/out_stall| earth_x/y/z, saturated
//
//  One item per cycle while no waiting result is stalled; an accepted item
//  passes through products, matrix entries, entry*accel multiplies, row sums,
//  divider entry, four long-division stages of 5 quotient bits, output reg.
//  Reset clears the valid bits only; the datapath registers are not reset.
//  The whole pipeline holds while a waiting result is stalled, so in_stall
//  is high exactly when out_valid and out_stall are both high.
//
module quaternion_frame_rotation_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [qfr_pkg::IN_W-1:0]     accel_x,
    input  logic signed [qfr_pkg::IN_W-1:0]     accel_y,
    input  logic signed [qfr_pkg::IN_W-1:0]     accel_z,
    input  logic signed [qfr_pkg::IN_W-1:0]     quat_w,
    input  logic signed [qfr_pkg::IN_W-1:0]     quat_x,
    input  logic signed [qfr_pkg::IN_W-1:0]     quat_y,
    input  logic signed [qfr_pkg::IN_W-1:0]     quat_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [qfr_pkg::EARTH_W-1:0]  earth_x,
    output logic signed [qfr_pkg::EARTH_W-1:0]  earth_y,
    output logic signed [qfr_pkg::EARTH_W-1:0]  earth_z,
    output logic                                saturated
);

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic signed [qfr_pkg::MAT_W-1:0] twice_sum(
        input logic signed [qfr_pkg::PROD_W-1:0] a,
        input logic signed [qfr_pkg::PROD_W-1:0] b
    );
        return (qfr_pkg::MAT_W'(a) + qfr_pkg::MAT_W'(b)) <<< 1;
    endfunction

    function automatic logic signed [qfr_pkg::MAT_W-1:0] twice_diff(
        input logic signed [qfr_pkg::PROD_W-1:0] a,
        input logic signed [qfr_pkg::PROD_W-1:0] b
    );
        return (qfr_pkg::MAT_W'(a) - qfr_pkg::MAT_W'(b)) <<< 1;
    endfunction

    // Restoring division by DIV_ODD, DIV_STEPS quotient bits
    function automatic qfr_pkg::div_t div_steps(input qfr_pkg::div_t d);
        qfr_pkg::div_t          cur;
        logic [qfr_pkg::R_W:0]  trial;
        logic                   ge;
        cur = d;
        for (int j = 0; j < qfr_pkg::DIV_STEPS; j++)
        begin
            trial   = {cur.rem, cur.low[qfr_pkg::Q_W-1]};
            ge      = (trial >= {1'b0, qfr_pkg::DIV_ODD});
            cur.low = cur.low << 1;
            cur.quo = {cur.quo[qfr_pkg::Q_W-2:0], ge};
            if (ge)
                cur.rem = qfr_pkg::R_W'(trial - {1'b0, qfr_pkg::DIV_ODD});
            else
                cur.rem = qfr_pkg::R_W'(trial);
        end
        return cur;
    endfunction

    // ------------------------------------------------------------------
    // Flow control: everything moves unless a waiting result is stalled
    // ------------------------------------------------------------------
    logic                               advance;
    logic [qfr_pkg::PIPE_DEPTH-1:0]     valid_reg;
    logic [qfr_pkg::PIPE_DEPTH-1:0]     valid_next;
    logic                               out_valid_reg;

    assign advance    = !out_valid_reg || !out_stall;
    assign in_stall   = !advance;
    assign valid_next = {valid_reg[qfr_pkg::PIPE_DEPTH-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg     <= valid_next;
            out_valid_reg <= valid_reg[qfr_pkg::PIPE_DEPTH-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: quaternion products
    // ------------------------------------------------------------------
    logic signed [qfr_pkg::PROD_W-1:0]  ww_reg, xx_reg, yy_reg, zz_reg, xy_reg;
    logic signed [qfr_pkg::PROD_W-1:0]  wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;
    logic signed [qfr_pkg::IN_W-1:0]    acc1_reg [3];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ww_reg      <= qfr_pkg::PROD_W'(quat_w) * qfr_pkg::PROD_W'(quat_w);
            xx_reg      <= qfr_pkg::PROD_W'(quat_x) * qfr_pkg::PROD_W'(quat_x);
            yy_reg      <= qfr_pkg::PROD_W'(quat_y) * qfr_pkg::PROD_W'(quat_y);
            zz_reg      <= qfr_pkg::PROD_W'(quat_z) * qfr_pkg::PROD_W'(quat_z);
            xy_reg      <= qfr_pkg::PROD_W'(quat_x) * qfr_pkg::PROD_W'(quat_y);
            wz_reg      <= qfr_pkg::PROD_W'(quat_w) * qfr_pkg::PROD_W'(quat_z);
            xz_reg      <= qfr_pkg::PROD_W'(quat_x) * qfr_pkg::PROD_W'(quat_z);
            wy_reg      <= qfr_pkg::PROD_W'(quat_w) * qfr_pkg::PROD_W'(quat_y);
            yz_reg      <= qfr_pkg::PROD_W'(quat_y) * qfr_pkg::PROD_W'(quat_z);
            wx_reg      <= qfr_pkg::PROD_W'(quat_w) * qfr_pkg::PROD_W'(quat_x);
            acc1_reg[0] <= accel_x;
            acc1_reg[1] <= accel_y;
            acc1_reg[2] <= accel_z;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: rotation matrix, row major, scale 10^8
    // ------------------------------------------------------------------
    logic signed [qfr_pkg::MAT_W-1:0]   m_next [9];
    logic signed [qfr_pkg::MAT_W-1:0]   m_reg  [9];
    logic signed [qfr_pkg::IN_W-1:0]    acc2_reg [3];

    always_comb
    begin
        m_next[0] = twice_sum(ww_reg, xx_reg) - qfr_pkg::QSCALE_SQ;
        m_next[1] = twice_diff(xy_reg, wz_reg);
        m_next[2] = twice_sum(xz_reg, wy_reg);
        m_next[3] = twice_sum(xy_reg, wz_reg);
        m_next[4] = twice_sum(ww_reg, yy_reg) - qfr_pkg::QSCALE_SQ;
        m_next[5] = twice_diff(yz_reg, wx_reg);
        m_next[6] = twice_diff(xz_reg, wy_reg);
        m_next[7] = twice_sum(yz_reg, wx_reg);
        m_next[8] = twice_sum(ww_reg, zz_reg) - qfr_pkg::QSCALE_SQ;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_reg    <= m_next;
            acc2_reg <= acc1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: entry * accel
    // ------------------------------------------------------------------
    logic signed [qfr_pkg::TERM_W-1:0]  term_next [9];
    logic signed [qfr_pkg::TERM_W-1:0]  term_reg  [9];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                term_next[r*3+c] = qfr_pkg::TERM_W'(m_reg[r*3+c])
                                 * qfr_pkg::TERM_W'(acc2_reg[c]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            term_reg <= term_next;
    end

    // ------------------------------------------------------------------
    // Stage 4: row sums
    // ------------------------------------------------------------------
    logic signed [qfr_pkg::SUM_W-1:0]   sum_next [3];
    logic signed [qfr_pkg::SUM_W-1:0]   sum_reg  [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sum_next[r] = qfr_pkg::SUM_W'(term_reg[r*3])
                        + qfr_pkg::SUM_W'(term_reg[r*3+1])
                        + qfr_pkg::SUM_W'(term_reg[r*3+2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            sum_reg <= sum_next;
    end

    // ------------------------------------------------------------------
    // Stage 5..9: magnitude, drop 2^8, then long division by 390625
    // ------------------------------------------------------------------
    qfr_pkg::div_t                      div_next [qfr_pkg::DIV_STAGES+1][3];
    qfr_pkg::div_t                      div_reg  [qfr_pkg::DIV_STAGES+1][3];
    logic [qfr_pkg::SUM_W-1:0]          mag [3];
    logic [qfr_pkg::U_W-1:0]            dvd [3];

    always_comb
    begin
        // divider entry: sign and magnitude, first remainder from the top bits
        for (int r = 0; r < 3; r++)
        begin
            div_next[0][r].neg  = sum_reg[r][qfr_pkg::SUM_W-1];
            mag[r]              = div_next[0][r].neg
                                ? qfr_pkg::SUM_W'(-sum_reg[r])
                                : qfr_pkg::SUM_W'(sum_reg[r]);
            dvd[r]              = mag[r][qfr_pkg::SUM_W-1:qfr_pkg::SHIFT_W];
            div_next[0][r].over = (dvd[r] >= qfr_pkg::OVER_LIM);
            div_next[0][r].rem  =
                dvd[r][qfr_pkg::Q_W+qfr_pkg::R_W-1:qfr_pkg::Q_W];
            div_next[0][r].low  = dvd[r][qfr_pkg::Q_W-1:0];
            div_next[0][r].quo  = '0;
        end
        // division stages
        for (int k = 1; k <= qfr_pkg::DIV_STAGES; k++)
        begin
            for (int r = 0; r < 3; r++)
                div_next[k][r] = div_steps(div_reg[k-1][r]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            div_reg <= div_next;
    end

    // ------------------------------------------------------------------
    // Output: apply sign, clip to 20 bits
    // ------------------------------------------------------------------
    qfr_pkg::earth_t                    earth_next [3];
    logic [2:0]                         clip;
    qfr_pkg::div_t                      fin [3];
    qfr_pkg::earth_t                    earth_reg [3];
    logic                               saturated_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            fin[r] = div_reg[qfr_pkg::DIV_STAGES][r];
            if (fin[r].neg)
            begin
                clip[r]       = fin[r].over || (fin[r].quo > qfr_pkg::NEG_LIMIT);
                earth_next[r] = clip[r] ? qfr_pkg::EARTH_MIN
                                        : qfr_pkg::EARTH_W'(-fin[r].quo);
            end
            else
            begin
                clip[r]       = fin[r].over || (fin[r].quo > qfr_pkg::POS_LIMIT);
                earth_next[r] = clip[r] ? qfr_pkg::EARTH_MAX
                                        : qfr_pkg::EARTH_W'(fin[r].quo);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            earth_reg     <= earth_next;
            saturated_reg <= |clip;
        end
    end

    assign out_valid = out_valid_reg;
    assign earth_x   = earth_reg[0];
    assign earth_y   = earth_reg[1];
    assign earth_z   = earth_reg[2];
    assign saturated = saturated_reg;

endmodule

// ===== design/qfr_checker.sv =====
// ============================================================================
// qfr_checker: port-level checks for quaternion_frame_rotation_top
// Watches the handshakes and the result fields over time.
// ============================================================================
module qfr_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic signed [qfr_pkg::EARTH_W-1:0]   earth_x,
    input logic signed [qfr_pkg::EARTH_W-1:0]   earth_y,
    input logic signed [qfr_pkg::EARTH_W-1:0]   earth_z,
    input logic                                 saturated
);

    // input side only backs up when a finished result is held
    a_stall_from_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall)
    ) else $error("in_stall without a stalled result");

    // a stalled result stays put
    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(earth_x)
            && $stable(earth_y) && $stable(earth_z) && $stable(saturated))
    ) else $error("stalled result changed");

    // a clipped item has at least one component at a range bound
    a_sat_at_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |->
            (earth_x == qfr_pkg::EARTH_MAX || earth_x == qfr_pkg::EARTH_MIN
          || earth_y == qfr_pkg::EARTH_MAX || earth_y == qfr_pkg::EARTH_MIN
          || earth_z == qfr_pkg::EARTH_MAX || earth_z == qfr_pkg::EARTH_MIN)
    ) else $error("saturated set with no component at a bound");

endmodule

bind quaternion_frame_rotation_top qfr_checker u_qfr_checker (.*);
